/* hdl/rth_dsp_pkg.sv */
// ============================================================================
// rth_dsp_pkg
// Shared types and codes of the difference smoothing penalty unit.
// ============================================================================
package rth_dsp_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int WINDOW_W   = 13;
    localparam int ORDER_CFG_W = 4;
    localparam int ORDER_W    = 5;   // holds any order up to 16
    localparam int GAIN_W     = 32;
    localparam int SUM_W      = 64;
    localparam int SCORE_W    = 63;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FIRST = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LAST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_ORDER   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 4'd3;

    localparam logic [WINDOW_W-1:0]    WINDOW_RESET = '0;
    localparam logic [ORDER_CFG_W-1:0] ORDER_RESET  = 4'd2;
    localparam logic [GAIN_W-1:0]      GAIN_RESET   = 32'd65536;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_BOUNDS_EQ   = 3'd1,
        STATUS_LAST_BEYOND = 3'd2,
        STATUS_FIRST_BELOW = 3'd3,
        STATUS_ORDER_LARGE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CASCADE,
        ST_SQUARE,
        ST_ACCUM,
        ST_COUNT,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load_x;
        logic diff_step;
        logic store_only;
        logic square;
        logic accum;
        logic mul_lo;
        logic mul_hi;
        logic scale;
        logic clear;
    } ctl_t;

endpackage

/* hdl/rth_dsp_ctrl.sv */
// ============================================================================
// rth_dsp_ctrl
// Sequencer: element position, window tracking, stage walk and status check.
// ============================================================================
module rth_dsp_ctrl #(
    parameter int MAX_ORDER  = 8,
    parameter int MAX_LENGTH = 4096,
    parameter int SW         = 3
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_final_element,
    input  logic [rth_dsp_pkg::WINDOW_W-1:0]       window_first,
    input  logic [rth_dsp_pkg::WINDOW_W-1:0]       window_last,
    input  logic [rth_dsp_pkg::ORDER_CFG_W-1:0]    diff_order,
    input  logic                                   out_free,
    output logic                                   in_ready,
    output rth_dsp_pkg::ctl_t                      ctl,
    output logic [SW-1:0]                          stage_idx,
    output rth_dsp_pkg::status_t                   status
);

    localparam int PW = $clog2(MAX_LENGTH + 1);
    localparam int VW = ((PW > rth_dsp_pkg::WINDOW_W) ? PW : rth_dsp_pkg::WINDOW_W) + 1;
    localparam int OW = rth_dsp_pkg::ORDER_W;
    localparam logic [PW-1:0] LEN_MAX = PW'(MAX_LENGTH);
    localparam logic [OW-1:0] R_MAX   = OW'(MAX_ORDER);

    rth_dsp_pkg::state_t  state_reg, state_next;
    logic [PW-1:0]        position_reg, position_next;
    logic [PW-1:0]        count_reg, count_next;
    logic [OW-1:0]        k_reg, k_next;
    logic                 last_reg, last_next;
    rth_dsp_pkg::status_t status_reg, status_next;

    logic            whole;
    logic [VW-1:0]   lo_v, hi_v, n_v, pos_inc, last_v, order_v;
    logic            room, in_win;
    logic [OW-1:0]   order_w, r_v;

    always_comb begin
        whole   = (window_first == '0) && (window_last == '0);
        lo_v    = whole ? VW'(1) : VW'(window_first);
        last_v  = VW'(window_last);
        n_v     = VW'(position_reg);
        hi_v    = whole ? n_v : last_v;
        pos_inc = n_v + VW'(1);
        room    = position_reg < LEN_MAX;
        in_win  = room && (pos_inc >= lo_v) && (whole || (pos_inc <= last_v));
        order_w = OW'(diff_order);
        order_v = VW'(diff_order);
        r_v     = (order_w > R_MAX) ? R_MAX : order_w;
    end

    always_comb begin
        state_next    = state_reg;
        position_next = position_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        last_next     = last_reg;
        status_next   = status_reg;
        ctl           = '0;
        unique case (state_reg)
            rth_dsp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ctl.load_x = 1'b1;
                    last_next  = s_final_element;
                    k_next     = '0;
                    if (room) begin
                        position_next = position_reg + PW'(1);
                    end
                    if (in_win) begin
                        state_next = rth_dsp_pkg::ST_CASCADE;
                    end else if (s_final_element) begin
                        state_next = rth_dsp_pkg::ST_CHECK;
                    end
                end
            end
            rth_dsp_pkg::ST_CASCADE: begin
                if (k_reg == r_v) begin
                    state_next = rth_dsp_pkg::ST_SQUARE;
                end else if (VW'(count_reg) == VW'(k_reg)) begin
                    // first arrival at this stage only primes it
                    ctl.store_only = 1'b1;
                    state_next     = rth_dsp_pkg::ST_COUNT;
                end else begin
                    ctl.diff_step = 1'b1;
                    k_next        = k_reg + OW'(1);
                end
            end
            rth_dsp_pkg::ST_SQUARE: begin
                ctl.square = 1'b1;
                state_next = rth_dsp_pkg::ST_ACCUM;
            end
            rth_dsp_pkg::ST_ACCUM: begin
                ctl.accum  = 1'b1;
                state_next = rth_dsp_pkg::ST_COUNT;
            end
            rth_dsp_pkg::ST_COUNT: begin
                if (count_reg < LEN_MAX) begin
                    count_next = count_reg + PW'(1);
                end
                state_next = last_reg ? rth_dsp_pkg::ST_CHECK : rth_dsp_pkg::ST_IDLE;
            end
            rth_dsp_pkg::ST_CHECK: begin
                priority if (hi_v == lo_v) begin
                    status_next = rth_dsp_pkg::STATUS_BOUNDS_EQ;
                end else if (hi_v > n_v) begin
                    status_next = rth_dsp_pkg::STATUS_LAST_BEYOND;
                end else if (lo_v == '0) begin
                    status_next = rth_dsp_pkg::STATUS_FIRST_BELOW;
                end else if ((hi_v < lo_v) || (order_v >= (hi_v - lo_v))
                             || (order_w > R_MAX)) begin
                    status_next = rth_dsp_pkg::STATUS_ORDER_LARGE;
                end else begin
                    status_next = rth_dsp_pkg::STATUS_OK;
                end
                state_next = (status_next == rth_dsp_pkg::STATUS_OK)
                             ? rth_dsp_pkg::ST_MUL_LO : rth_dsp_pkg::ST_EMIT;
            end
            rth_dsp_pkg::ST_MUL_LO: begin
                ctl.mul_lo = 1'b1;
                state_next = rth_dsp_pkg::ST_MUL_HI;
            end
            rth_dsp_pkg::ST_MUL_HI: begin
                ctl.mul_hi = 1'b1;
                state_next = rth_dsp_pkg::ST_SCALE;
            end
            rth_dsp_pkg::ST_SCALE: begin
                ctl.scale  = 1'b1;
                state_next = rth_dsp_pkg::ST_EMIT;
            end
            rth_dsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    ctl.clear     = 1'b1;
                    position_next = '0;
                    count_next    = '0;
                    state_next    = rth_dsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rth_dsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rth_dsp_pkg::ST_IDLE;
            position_reg <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            last_reg     <= 1'b0;
            status_reg   <= rth_dsp_pkg::STATUS_OK;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
        end
    end

    assign in_ready  = (state_reg == rth_dsp_pkg::ST_IDLE);
    assign stage_idx = k_reg[SW-1:0];
    assign status    = status_reg;

    a_stage_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rth_dsp_pkg::ST_CASCADE) |-> (k_reg <= R_MAX))
        else $error("stage index past deepest stage");

    a_count_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= position_reg)
        else $error("window count ahead of position");

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear |=> (position_reg == '0) && (count_reg == '0))
        else $error("vector state not cleared after result");

endmodule

/* hdl/rth_dsp_datapath.sv */
// ============================================================================
// rth_dsp_datapath
// Stage registers, shared subtractor and multiplier, square-sum accumulator.
// ============================================================================
module rth_dsp_datapath #(
    parameter int MAX_ORDER = 8,
    parameter int SW        = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rth_dsp_pkg::ctl_t                    ctl,
    input  logic [SW-1:0]                        stage_idx,
    input  logic signed [rth_dsp_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [rth_dsp_pkg::GAIN_W-1:0]       gain,
    output logic [rth_dsp_pkg::SCORE_W-1:0]      score
);

    localparam int DW = rth_dsp_pkg::SAMPLE_W + MAX_ORDER + 1;
    localparam int XW = DW - rth_dsp_pkg::SAMPLE_W;
    localparam logic [rth_dsp_pkg::SUM_W-1:0] P_HI_LIMIT = 64'h0000_8000_0000_0000;
    localparam logic [rth_dsp_pkg::SUM_W-1:0] SCORE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    logic signed [DW-1:0] stage_reg [MAX_ORDER];
    logic signed [DW-1:0] x_reg;
    logic [63:0]          prod_reg;
    logic [63:0]          plo_reg;
    logic [63:0]          sum_reg;
    logic                 sat_reg;
    logic                 big_reg;
    logic [rth_dsp_pkg::SCORE_W-1:0] score_reg;

    logic signed [DW-1:0] prev;
    logic [DW-1:0]        mag;
    logic [31:0]          op_a, op_b;
    logic [63:0]          mul_out;
    logic [64:0]          acc_sum;
    logic [63:0]          scaled;

    always_comb begin
        prev = stage_reg[stage_idx];
        mag  = x_reg[DW-1] ? DW'(-x_reg) : DW'(x_reg);
        op_a = mag[31:0];
        op_b = mag[31:0];
        if (ctl.mul_lo) begin
            op_a = sum_reg[31:0];
            op_b = gain;
        end else if (ctl.mul_hi) begin
            op_a = sum_reg[63:32];
            op_b = gain;
        end
        mul_out = {32'd0, op_a} * {32'd0, op_b};
        acc_sum = {1'b0, sum_reg} + {1'b0, prod_reg};
        // prod_reg holds the high partial product during the scale step
        scaled  = {1'b0, prod_reg[46:0], 16'd0} + {16'd0, plo_reg[63:16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                stage_reg[i] <= '0;
            end
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end else if (ctl.clear) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                stage_reg[i] <= '0;
            end
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end else begin
            if (ctl.diff_step || ctl.store_only) begin
                stage_reg[stage_idx] <= x_reg;
            end
            if (ctl.accum && !sat_reg) begin
                if (big_reg || acc_sum[64]) begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end else begin
                    sum_reg <= acc_sum[63:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_x) begin
            x_reg <= {{XW{s_sample[rth_dsp_pkg::SAMPLE_W-1]}}, s_sample};
        end else if (ctl.diff_step) begin
            x_reg <= x_reg - prev;
        end
        if (ctl.square || ctl.mul_lo || ctl.mul_hi) begin
            prod_reg <= mul_out;
        end
        if (ctl.square) begin
            big_reg <= |mag[DW-1:32];
        end
        if (ctl.mul_hi) begin
            plo_reg <= prod_reg;
        end
        if (ctl.scale) begin
            if (prod_reg >= P_HI_LIMIT || scaled > SCORE_MAX) begin
                score_reg <= SCORE_MAX[rth_dsp_pkg::SCORE_W-1:0];
            end else begin
                score_reg <= scaled[rth_dsp_pkg::SCORE_W-1:0];
            end
        end
    end

    assign score = score_reg;

endmodule

/* hdl/rth_difference_smoothing_penalty_unit.sv */
// ============================================================================
// rth_difference_smoothing_penalty_unit
// Sum of squared order-r differences over a window, scaled by a gain.
// ============================================================================
// Usage:
//   Elements enter on s_sample / s_final_element (valid/ready). Each element
//   inside the window is walked through the difference stages one stage a
//   cycle by a shared subtractor, then squared and accumulated through one
//   shared 32x32 multiplier. The request marked final produces one result
//   on m_score / m_status (valid/ready); all other requests produce none.
//   An element outside the window skips the stages; one that primes stage t
//   stops there, and only a full order-r difference is squared and summed.
//   A final element adds two partial products and the scale step, or neither
//   when the status is an error. s_ready is low while an element is in
//   flight. The result sits in an output register; a new vector may start
//   while it waits, and only the next final result waits for m_ready.
//   Configuration (cfg_*) is taken every cycle; write it only while idle.
//   Synchronous reset clears the vector state and loads register defaults
//   (whole vector, order 2, gain 1.0); no clearing pass is needed.
// ============================================================================
module rth_difference_smoothing_penalty_unit #(
    parameter int MAX_ORDER  = 8,
    parameter int MAX_LENGTH = 4096
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [rth_dsp_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                     s_final_element,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [rth_dsp_pkg::SCORE_W-1:0]          m_score,
    output logic [2:0]                               m_status,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [rth_dsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rth_dsp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic [rth_dsp_pkg::WINDOW_W-1:0]    first_reg;
    logic [rth_dsp_pkg::WINDOW_W-1:0]    last_reg;
    logic [rth_dsp_pkg::ORDER_CFG_W-1:0] order_reg;
    logic [rth_dsp_pkg::GAIN_W-1:0]      gain_reg;

    logic                            m_valid_reg;
    logic [rth_dsp_pkg::SCORE_W-1:0] m_score_reg;
    rth_dsp_pkg::status_t            m_status_reg;

    rth_dsp_pkg::ctl_t               ctl;
    logic [SW-1:0]                   stage_idx;
    rth_dsp_pkg::status_t            status;
    logic [rth_dsp_pkg::SCORE_W-1:0] score;
    logic                            out_free;
    logic                            in_ready;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= rth_dsp_pkg::WINDOW_RESET;
            last_reg  <= rth_dsp_pkg::WINDOW_RESET;
            order_reg <= rth_dsp_pkg::ORDER_RESET;
            gain_reg  <= rth_dsp_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rth_dsp_pkg::REG_WINDOW_FIRST: first_reg <= cfg_data[rth_dsp_pkg::WINDOW_W-1:0];
                rth_dsp_pkg::REG_WINDOW_LAST:  last_reg  <= cfg_data[rth_dsp_pkg::WINDOW_W-1:0];
                rth_dsp_pkg::REG_DIFF_ORDER:   order_reg <= cfg_data[rth_dsp_pkg::ORDER_CFG_W-1:0];
                rth_dsp_pkg::REG_GAIN:         gain_reg  <= cfg_data[rth_dsp_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rth_dsp_ctrl #(
        .MAX_ORDER  (MAX_ORDER),
        .MAX_LENGTH (MAX_LENGTH),
        .SW         (SW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_final_element (s_final_element),
        .window_first    (first_reg),
        .window_last     (last_reg),
        .diff_order      (order_reg),
        .out_free        (out_free),
        .in_ready        (in_ready),
        .ctl             (ctl),
        .stage_idx       (stage_idx),
        .status          (status)
    );

    rth_dsp_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .SW        (SW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stage_idx (stage_idx),
        .s_sample  (s_sample),
        .gain      (gain_reg),
        .score     (score)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            m_status_reg <= status;
            m_score_reg  <= (status == rth_dsp_pkg::STATUS_OK) ? score : '0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_score  = m_score_reg;
    assign m_status = m_status_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear |-> out_free)
        else $error("result loaded over a pending one");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.diff_step || ctl.square || ctl.mul_lo) |-> !s_ready)
        else $error("input ready while an element is in flight");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != rth_dsp_pkg::STATUS_OK) |-> (m_score_reg == '0))
        else $error("error result with nonzero score");

endmodule

/* bench/rth_difference_smoothing_penalty_unit_tb.sv */
// ============================================================================
// rth_difference_smoothing_penalty_unit_tb
// Self-checking bench for the difference smoothing penalty unit. A directed
// table hits the status codes and arithmetic extremes, then random vectors
// run under four idling mixes. Directed results are held to typed-in values;
// random ones to an in-bench model of the difference cascade and gain scaling.
// ============================================================================
module rth_difference_smoothing_penalty_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER       = 8;
    localparam int MAX_LENGTH      = 4096;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int SCORE_W  = rth_dsp_pkg::SCORE_W;
    localparam int SAMPLE_W = rth_dsp_pkg::SAMPLE_W;
    localparam int WIN_W    = rth_dsp_pkg::WINDOW_W;
    localparam int ORD_W    = rth_dsp_pkg::ORDER_CFG_W;
    localparam int GAIN_W   = rth_dsp_pkg::GAIN_W;
    localparam int IDX_W    = rth_dsp_pkg::CFG_IDX_W;
    localparam int DATA_W   = rth_dsp_pkg::CFG_DATA_W;
    localparam int SUM_W    = rth_dsp_pkg::SUM_W;
    localparam logic [SCORE_W-1:0] SCORE_CAP = {SCORE_W{1'b1}};

    typedef struct packed {
        logic [SCORE_W-1:0]   score;
        rth_dsp_pkg::status_t status;
    } penalty_t;

    typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [IDX_W-1:0]     reg_idx;
        logic [31:0]          value;
        logic                 fin;
        logic                 pinned;
        logic [SCORE_W-1:0]   score;
        rth_dsp_pkg::status_t status;
    } stim_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample = '0;
    logic                        s_final_element = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [SCORE_W-1:0]          m_score;
    logic [2:0]                  m_status;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [IDX_W-1:0]            cfg_index = '0;
    logic [DATA_W-1:0]           cfg_data = '0;

    // typed-in expectation, carried alongside the request payload
    logic     pin_flag = 1'b0;
    penalty_t pin_value = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    // model copy of registers and vector state
    logic [WIN_W-1:0]  win_first = rth_dsp_pkg::WINDOW_RESET;
    logic [WIN_W-1:0]  win_last  = rth_dsp_pkg::WINDOW_RESET;
    logic [ORD_W-1:0]  order_cfg = rth_dsp_pkg::ORDER_RESET;
    logic [GAIN_W-1:0] gain_cfg  = rth_dsp_pkg::GAIN_RESET;
    longint            stage_prev [MAX_ORDER] = '{default: 0};
    int unsigned       seen_count = 0;
    int unsigned       window_count = 0;
    logic [SUM_W-1:0]  square_sum = '0;

    stim_row_t directed_rows [$];
    penalty_t  scores_pending [$];
    int samples_taken = 0;
    int scores_seen   = 0;
    int finals_sent   = 0;
    int reg_writes    = 0;
    int errors        = 0;
    int quiet_cycles  = 0;
    int status_hits [5] = '{default: 0};

    rth_difference_smoothing_penalty_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_final_element (s_final_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_score         (m_score),
        .m_status        (m_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Runs one element through the difference cascade; on the final element
    // returns 1 with the scored penalty and clears the vector state.
    function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] smp,
                                       input logic fin, output penalty_t res);
        longint               x, nxt;
        logic [63:0]          mag, sq;
        logic [95:0]          prod;
        bit                   whole, full;
        int unsigned          lo, hi, r, k;
        rth_dsp_pkg::status_t st;
        whole = (win_first == '0) && (win_last == '0);
        lo    = whole ? 1 : win_first;
        x     = smp;
        res   = '0;
        if (seen_count < MAX_LENGTH) begin
            seen_count++;
            if (seen_count >= lo && (whole || seen_count <= win_last)) begin
                r = (order_cfg > MAX_ORDER) ? MAX_ORDER : order_cfg;
                full = 1'b1;
                for (k = 0; k < r && full; k++) begin
                    nxt = x - stage_prev[k];
                    stage_prev[k] = x;
                    // stage still priming: no difference leaves it yet
                    if (window_count == k) full = 1'b0;
                    else x = nxt;
                end
                if (full) begin
                    mag = (x < 0) ? -x : x;
                    if (mag > 64'hFFFF_FFFF) begin
                        square_sum = '1;
                    end else begin
                        sq = mag * mag;
                        square_sum = (square_sum > ~sq) ? '1 : square_sum + sq;
                    end
                end
                if (window_count < MAX_LENGTH) window_count++;
            end
        end
        if (fin) begin
            hi = whole ? seen_count : win_last;
            if (hi == lo) st = rth_dsp_pkg::STATUS_BOUNDS_EQ;
            else if (hi > seen_count) st = rth_dsp_pkg::STATUS_LAST_BEYOND;
            else if (lo < 1) st = rth_dsp_pkg::STATUS_FIRST_BELOW;
            else if (hi < lo || order_cfg >= hi - lo || order_cfg > MAX_ORDER)
                st = rth_dsp_pkg::STATUS_ORDER_LARGE;
            else st = rth_dsp_pkg::STATUS_OK;
            res.status = st;
            if (st == rth_dsp_pkg::STATUS_OK) begin
                prod = {32'd0, square_sum} * {64'd0, gain_cfg};
                res.score = (prod[95:16] > {17'd0, SCORE_CAP}) ? SCORE_CAP : prod[78:16];
            end
            seen_count   = 0;
            window_count = 0;
            square_sum   = '0;
            for (k = 0; k < MAX_ORDER; k++) stage_prev[k] = 0;
        end
        return fin;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
        endcase
    endfunction

    function automatic stim_row_t reg_row(input logic [IDX_W-1:0] idx,
                                          input logic [31:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.value = val;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input logic [31:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.value = val;
        return row;
    endfunction

    function automatic stim_row_t final_row(input logic [31:0] val,
                                            input logic [SCORE_W-1:0] score,
                                            input rth_dsp_pkg::status_t st);
        stim_row_t row;
        row = sample_row(val);
        row.fin = 1'b1;
        row.pinned = 1'b1;
        row.score = score;
        row.status = st;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    task automatic send_sample(input logic [31:0] smp, input logic fin,
                               input logic pinned, input penalty_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample        <= smp;
        s_final_element <= fin;
        pin_flag        <= pinned;
        pin_value       <= want;
        if (fin) finals_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain all outstanding scores, then give the datapath time to go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (scores_seen != finals_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_all(input logic [WIN_W-1:0] first, input logic [WIN_W-1:0] last,
                             input logic [ORD_W-1:0] order, input logic [GAIN_W-1:0] gain);
        settle();
        write_reg(rth_dsp_pkg::REG_WINDOW_FIRST, DATA_W'(first));
        write_reg(rth_dsp_pkg::REG_WINDOW_LAST, DATA_W'(last));
        write_reg(rth_dsp_pkg::REG_DIFF_ORDER, DATA_W'(order));
        write_reg(rth_dsp_pkg::REG_GAIN, gain);
    endtask

    // One register setting followed by a few vectors; mostly well-formed
    // windows, with a share of error and out-of-range bounds.
    task automatic run_setting(output int sent);
        logic [WIN_W-1:0]  first, last;
        logic [ORD_W-1:0]  order;
        logic [GAIN_W-1:0] gain;
        int unsigned       mode, len_lo, len_hi, len, nvec, v, i;
        bit                whole;
        order = ORD_W'(($urandom_range(99) < 88) ? $urandom_range(0, 8)
                                                  : $urandom_range(9, 15));
        mode  = $urandom_range(99);
        whole = 1'b0;
        if (mode < 45) begin
            first = '0;
            last = '0;
            whole = 1'b1;
            len_lo = order + 2;
            len_hi = order + 16;
        end else if (mode < 85) begin
            first = WIN_W'($urandom_range(1, 6));
            last = WIN_W'(first + order + 1 + $urandom_range(0, 10));
            len_lo = last;
            len_hi = last + 6;
        end else if (mode < 93) begin
            first = WIN_W'($urandom_range(0, 12));
            last = WIN_W'($urandom_range(0, 16));
            len_lo = 1;
            len_hi = 20;
        end else begin
            case ($urandom_range(3))
                0: begin first = 13'd4096; last = 13'd4096; end
                1: begin first = '1; last = '1; end
                2: begin first = '0; last = '1; end
                default: begin first = WIN_W'($urandom); last = WIN_W'($urandom); end
            endcase
            len_lo = 1;
            len_hi = 12;
        end
        case ($urandom_range(19))
            0, 1:    gain = '0;
            2, 3:    gain = '1;
            4, 5, 6: gain = $urandom;
            7:       gain = rth_dsp_pkg::GAIN_RESET;
            default: gain = $urandom_range(32'h4000, 32'h4_0000);
        endcase
        write_all(first, last, order, gain);
        nvec = $urandom_range(2, 4);
        sent = 0;
        for (v = 0; v < nvec; v++) begin
            len = $urandom_range(len_lo, len_hi);
            if ($urandom_range(9) == 0) len = $urandom_range(1, whole ? 3 : len_hi);
            for (i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1, 1'b0, '0);
            sent += len;
        end
    endtask

    // predictor: follows every accepted register write and request
    always @(posedge aclk) begin : track_requests
        penalty_t res;
        if (aresetn && cfg_valid && cfg_ready) begin
            reg_writes++;
            case (cfg_index)
                rth_dsp_pkg::REG_WINDOW_FIRST: win_first = cfg_data[WIN_W-1:0];
                rth_dsp_pkg::REG_WINDOW_LAST:  win_last  = cfg_data[WIN_W-1:0];
                rth_dsp_pkg::REG_DIFF_ORDER:   order_cfg = cfg_data[ORD_W-1:0];
                rth_dsp_pkg::REG_GAIN:         gain_cfg  = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
        if (aresetn && s_valid && s_ready) begin
            samples_taken++;
            if (fold_sample(s_sample, s_final_element, res)) begin
                if (pin_flag) res = pin_value;
                scores_pending = {scores_pending, res};
            end
        end
    end

    always @(posedge aclk) begin : check_scores
        penalty_t want;
        if (aresetn && m_valid && m_ready) begin
            scores_seen++;
            if (scores_pending.size() == 0) begin
                if (errors < 10)
                    $display("unexpected score %h status %0d at %t", m_score, m_status, $realtime);
                errors++;
            end else begin
                want = scores_pending.pop_front();
                status_hits[want.status]++;
                if (m_score !== want.score || m_status !== want.status) begin
                    if (errors < 10)
                        $display("mismatch at %t: score exp %h got %h, status exp %0d got %0d",
                                 $realtime, want.score, m_score, want.status, m_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        penalty_t  want;
        int        phase, taken, n;
        // defaults after reset: whole vector, order 2, unity gain
        add_row(sample_row(32'h0000_0000));
        add_row(sample_row(32'h0001_0000));
        add_row(sample_row(32'h0004_0000));
        add_row(final_row(32'h0009_0000, 63'h8_0000_0000, rth_dsp_pkg::STATUS_OK));
        // single element: bounds collapse
        add_row(final_row(32'h8000_0000, '0, rth_dsp_pkg::STATUS_BOUNDS_EQ));
        // three elements cannot carry an order-2 difference
        add_row(sample_row(32'h7FFF_FFFF));
        add_row(sample_row(32'h8000_0000));
        add_row(final_row(32'h7FFF_FFFF, '0, rth_dsp_pkg::STATUS_ORDER_LARGE));
        // window end past the vector length
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_FIRST, 32'd2));
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_LAST, 32'd9));
        add_row(sample_row(32'h0000_0001));
        add_row(sample_row(32'hFFFF_FFFF));
        add_row(sample_row(32'h1234_5678));
        add_row(sample_row(32'hEDCB_A987));
        add_row(final_row(32'h0000_0000, '0, rth_dsp_pkg::STATUS_LAST_BEYOND));
        // window start of zero with a nonzero end
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_FIRST, 32'd0));
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_LAST, 32'd5));
        add_row(sample_row(32'h5555_5555));
        add_row(sample_row(32'hAAAA_AAAA));
        add_row(sample_row(32'h0001_0000));
        add_row(sample_row(32'hFFFF_0000));
        add_row(sample_row(32'h7FFF_FFFF));
        add_row(final_row(32'h8000_0000, '0, rth_dsp_pkg::STATUS_FIRST_BELOW));
        // end below start
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_FIRST, 32'd5));
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_LAST, 32'd3));
        add_row(sample_row(32'h0000_ffff));
        add_row(sample_row(32'hffff_0001));
        add_row(final_row(32'h0100_0000, '0, rth_dsp_pkg::STATUS_ORDER_LARGE));
        // order 0 on the extremes with full gain saturates the score
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_FIRST, 32'd0));
        add_row(reg_row(rth_dsp_pkg::REG_WINDOW_LAST, 32'd0));
        add_row(reg_row(rth_dsp_pkg::REG_DIFF_ORDER, 32'd0));
        add_row(reg_row(rth_dsp_pkg::REG_GAIN, 32'hFFFF_FFFF));
        add_row(sample_row(32'h7FFF_FFFF));
        add_row(final_row(32'h8000_0000, SCORE_CAP, rth_dsp_pkg::STATUS_OK));
        // order beyond the cascade depth
        add_row(reg_row(rth_dsp_pkg::REG_DIFF_ORDER, 32'd15));
        add_row(reg_row(rth_dsp_pkg::REG_GAIN, rth_dsp_pkg::GAIN_RESET));
        add_row(sample_row(32'h0003_0000));
        add_row(final_row(32'hFFFD_0000, '0, rth_dsp_pkg::STATUS_ORDER_LARGE));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                want.score  = directed_rows[i].score;
                want.status = directed_rows[i].status;
                send_sample(directed_rows[i].value, directed_rows[i].fin,
                            directed_rows[i].pinned, want);
            end
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 77; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            taken = 0;
            while (taken < ITEMS_PER_PHASE) begin
                run_setting(n);
                taken += n;
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (scores_pending.size() != 0) begin
            $display("%0d expected scores never arrived", scores_pending.size());
            errors += scores_pending.size();
        end
        $display("Covered %0d samples, %0d register writes, %0d scores", samples_taken,
                 reg_writes, scores_seen);
        $display("Scores by status: ok %0d, bounds %0d, beyond %0d, first %0d, order %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
